@@ src/mhd_pkg.sv @@
package mhd_pkg;

    // Field widths of the pixel, result and configuration words.
    localparam int CMD_W   = 2;
    localparam int PIXEL_W = 8;
    localparam int WIDTH_W = 11;
    localparam int SQ_W    = 21;
    localparam int Q8_W    = 19;

    // Fractional bits of the Q8 distance come from scaling the square by 2^16.
    localparam int FRAC_SQ_BITS = 16;

    // Command codes carried in the cmd field.
    localparam logic [CMD_W-1:0] CMD_FIRST   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SECOND  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // Image width after reset.
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd1024;

    // Saturation limits of the result fields.
    localparam logic [SQ_W-1:0] SQ_MAX = '1;
    localparam logic [Q8_W-1:0] Q8_MAX = '1;

endpackage

@@ src/mhd_in_if.sv @@
interface mhd_in_if;
    logic                         valid;
    logic                         ready;
    logic [mhd_pkg::CMD_W-1:0]    cmd;
    logic [mhd_pkg::PIXEL_W-1:0]  pixel;

    modport source (output valid, output cmd, output pixel, input ready);
    modport sink   (input valid, input cmd, input pixel, output ready);
endinterface

@@ src/mhd_out_if.sv @@
interface mhd_out_if;
    logic                       valid;
    logic                       ready;
    logic [mhd_pkg::SQ_W-1:0]   hausdorff_squared;
    logic [mhd_pkg::Q8_W-1:0]   hausdorff_q8;
    logic                       either_empty;
    logic                       overflow;

    modport source (output valid, output hausdorff_squared, output hausdorff_q8,
                    output either_empty, output overflow, input ready);
    modport sink   (input valid, input hausdorff_squared, input hausdorff_q8,
                    input either_empty, input overflow, output ready);
endinterface

@@ src/mhd_cfg_if.sv @@
interface mhd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mhd_pkg::WIDTH_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/mhd_point_mem.sv @@
module mhd_point_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/mhd_loader.sv @@
module mhd_loader #(
    parameter int MAX_DIM    = 1024,
    parameter int MAX_POINTS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                take,
    input  logic                                active,
    input  logic                                clear,
    input  logic [$clog2(MAX_DIM+1)-1:0]        eff_width,
    output logic [$clog2(MAX_POINTS+1)-1:0]     count,
    output logic                                we,
    output logic [$clog2(MAX_POINTS)-1:0]       waddr,
    output logic [2*$clog2(MAX_DIM)-1:0]        wdata,
    output logic                                drop
);

    localparam int XW = $clog2(MAX_DIM);
    localparam int EW = $clog2(MAX_DIM+1);
    localparam int CW = $clog2(MAX_POINTS+1);

    logic [XW-1:0] column_reg, column_next;
    logic [EW-1:0] row_reg, row_next;
    logic [CW-1:0] count_reg, count_next;
    logic          blocked;
    logic          full;
    logic [EW-1:0] col_inc;

    always_comb
    begin
        blocked = row_reg >= EW'(MAX_DIM);
        full    = count_reg == CW'(MAX_POINTS);
        col_inc = EW'(column_reg) + EW'(1);

        we    = take && !blocked && active && !full;
        drop  = take && (blocked || (active && full));
        waddr = count_reg[$clog2(MAX_POINTS)-1:0];
        wdata = {row_reg[XW-1:0], column_reg};

        column_next = column_reg;
        row_next    = row_reg;
        count_next  = count_reg;
        if (clear)
        begin
            column_next = '0;
            row_next    = '0;
            count_next  = '0;
        end
        else if (take && !blocked)
        begin
            if (we)
            begin
                count_next = count_reg + CW'(1);
            end
            if (col_inc >= eff_width)
            begin
                column_next = '0;
                row_next    = row_reg + EW'(1);
            end
            else
            begin
                column_next = col_inc[XW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            count_reg  <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            count_reg  <= count_next;
        end
    end

    assign count = count_reg;

endmodule

@@ src/mhd_scan.sv @@
module mhd_scan #(
    parameter int MAX_DIM    = 1024,
    parameter int MAX_POINTS = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [$clog2(MAX_POINTS+1)-1:0]  count_first,
    input  logic [$clog2(MAX_POINTS+1)-1:0]  count_second,
    output logic [$clog2(MAX_POINTS)-1:0]    raddr_first,
    output logic [$clog2(MAX_POINTS)-1:0]    raddr_second,
    input  logic [2*$clog2(MAX_DIM)-1:0]     rdata_first,
    input  logic [2*$clog2(MAX_DIM)-1:0]     rdata_second,
    output logic                             done,
    output logic [2*$clog2(MAX_DIM):0]       best
);

    localparam int XW  = $clog2(MAX_DIM);
    localparam int SQW = 2 * XW;
    localparam int DW  = SQW + 1;
    localparam int CW  = $clog2(MAX_POINTS+1);
    localparam int AW  = $clog2(MAX_POINTS);

    typedef struct packed {
        logic valid;
        logic first;
        logic last_j;
        logic last_all;
    } tag_t;

    logic          active_reg, active_next;
    logic          dir_reg, dir_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    tag_t          tag1_reg, tag1_next;
    tag_t          tag2_reg;
    tag_t          tag3_reg;
    logic [XW-1:0] dx_reg, dx_next;
    logic [XW-1:0] dy_reg, dy_next;
    logic [SQW-1:0] dx2_reg, dy2_reg;
    logic [DW-1:0] mn_reg, mn_next;
    logic [DW-1:0] best_reg, best_next;
    logic          done_reg;

    logic [CW-1:0] n_outer, n_inner;
    logic          last_i, last_j;
    logic [XW-1:0] fx, fy, sx, sy;
    logic [DW-1:0] pair_d2;

    // Issue side: walk every (i, j) pair of one direction, then swap the roles.
    always_comb
    begin
        n_outer = dir_reg ? count_second : count_first;
        n_inner = dir_reg ? count_first  : count_second;
        last_j  = (CW'(j_reg) + CW'(1)) == n_inner;
        last_i  = (CW'(i_reg) + CW'(1)) == n_outer;

        raddr_first  = dir_reg ? j_reg : i_reg;
        raddr_second = dir_reg ? i_reg : j_reg;

        tag1_next.valid    = active_reg;
        tag1_next.first    = j_reg == '0;
        tag1_next.last_j   = last_j;
        tag1_next.last_all = last_j && last_i && dir_reg;

        active_next = active_reg;
        dir_next    = dir_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        if (start)
        begin
            active_next = 1'b1;
            dir_next    = 1'b0;
            i_next      = '0;
            j_next      = '0;
        end
        else if (active_reg)
        begin
            if (last_j)
            begin
                j_next = '0;
                if (last_i)
                begin
                    i_next = '0;
                    if (dir_reg)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        dir_next = 1'b1;
                    end
                end
                else
                begin
                    i_next = i_reg + AW'(1);
                end
            end
            else
            begin
                j_next = j_reg + AW'(1);
            end
        end
    end

    // Distance is symmetric, so the two memories feed the same lanes in both directions.
    always_comb
    begin
        fx = rdata_first[XW-1:0];
        fy = rdata_first[SQW-1:XW];
        sx = rdata_second[XW-1:0];
        sy = rdata_second[SQW-1:XW];
        dx_next = (fx > sx) ? (fx - sx) : (sx - fx);
        dy_next = (fy > sy) ? (fy - sy) : (sy - fy);
    end

    always_comb
    begin
        pair_d2 = DW'(dx2_reg) + DW'(dy2_reg);
        if (tag3_reg.first || (pair_d2 < mn_reg))
        begin
            mn_next = pair_d2;
        end
        else
        begin
            mn_next = mn_reg;
        end
        best_next = best_reg;
        if (start)
        begin
            best_next = '0;
        end
        else if (tag3_reg.valid && tag3_reg.last_j && (mn_next > best_reg))
        begin
            best_next = mn_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            dir_reg    <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            tag1_reg   <= '0;
            tag2_reg   <= '0;
            tag3_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            dir_reg    <= dir_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            tag1_reg   <= tag1_next;
            tag2_reg   <= tag1_reg;
            tag3_reg   <= tag2_reg;
            done_reg   <= tag3_reg.valid && tag3_reg.last_all;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dx2_reg  <= SQW'(dx_reg) * SQW'(dx_reg);
        dy2_reg  <= SQW'(dy_reg) * SQW'(dy_reg);
        if (tag3_reg.valid)
        begin
            mn_reg <= mn_next;
        end
        best_reg <= best_next;
    end

    assign done = done_reg;
    assign best = best_reg;

endmodule

@@ src/mhd_isqrt.sv @@
module mhd_isqrt #(
    parameter int RADW = 38
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RADW-1:0]   radicand,
    output logic              done,
    output logic [RADW/2-1:0] root
);

    localparam int QW = RADW / 2;
    localparam int SW = $clog2(QW);

    logic            busy_reg;
    logic            done_reg;
    logic [SW-1:0]   step_reg;
    logic [RADW-1:0] rad_reg;
    logic [QW:0]     rem_reg;
    logic [QW-1:0]   root_reg;

    logic [QW+2:0]   rem_sh;
    logic [QW+2:0]   trial;
    logic [QW+2:0]   diff;
    logic            fits;

    // One result bit per cycle, two radicand bits brought down each step.
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RADW-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        fits   = rem_sh >= trial;
        diff   = rem_sh - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(QW-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RADW-3:0], 2'b00};
            rem_reg  <= fits ? diff[QW:0] : rem_sh[QW:0];
            root_reg <= {root_reg[QW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ src/mask_hausdorff_distance.sv @@
// Symmetric Hausdorff distance between two binary masks. Words with cmd 0 and cmd 1
// carry the pixels of the first and second mask in raster order, one word per clock;
// each nonzero pixel is stored as an (x,y) point in that mask's point memory, and rows
// wrap at image_width (0 acts as 1, values above MAX_DIM act as MAX_DIM). A word with
// cmd 2 starts the compute pass: the scan engine reads one pair of points per clock
// from the two memories, over every pair in both directions, and through its pipeline
// hands the largest minimum to a square root unit that yields one bit a clock; the
// result then moves through a pending slot into the output register. The block takes
// no pixel words while a compute pass runs or its result waits for the output register.
// The result word gives the squared distance, its Q8 square root and the overflow
// flag; both sets are cleared as the result moves to the pending slot. If either set
// is empty the distances are zero, either_empty is set and the result goes straight
// to the pending slot with no scan or root. cmd 3 is accepted and ignored. Overflow
// is raised when a pixel is dropped because its set is full or its row lies at or
// beyond MAX_DIM.
// The point memories need no clearing after reset: the point counts bound every read.
module mask_hausdorff_distance #(
    parameter int MAX_DIM    = 1024,
    parameter int MAX_POINTS = 4096
) (
    input  logic     clk,
    input  logic     rst_n,
    mhd_in_if.sink   pixels,
    mhd_cfg_if.sink  cfg,
    mhd_out_if.source results
);

    localparam int XW   = $clog2(MAX_DIM);
    localparam int PW   = 2 * XW;
    localparam int DW   = PW + 1;
    localparam int EW   = $clog2(MAX_DIM+1);
    localparam int CMPW = (EW > mhd_pkg::WIDTH_W) ? EW : mhd_pkg::WIDTH_W;
    localparam int CW   = $clog2(MAX_POINTS+1);
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int RADW = ((DW + mhd_pkg::FRAC_SQ_BITS + 1) / 2) * 2;
    localparam int QW   = RADW / 2;
    localparam int SQE  = (DW > mhd_pkg::SQ_W) ? DW : mhd_pkg::SQ_W;
    localparam int QE   = (QW > mhd_pkg::Q8_W) ? QW : mhd_pkg::Q8_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ROOT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [mhd_pkg::WIDTH_W-1:0] image_width_reg;
    logic                        overflow_reg, overflow_next;

    // Result waiting for the output register, and the output register itself.
    logic [mhd_pkg::SQ_W-1:0] pend_sq_reg, pend_sq_next;
    logic [mhd_pkg::Q8_W-1:0] pend_q8_reg, pend_q8_next;
    logic                     pend_empty_reg, pend_empty_next;
    logic                     pend_ovf_reg, pend_ovf_next;
    logic                     out_valid_reg, out_valid_next;
    logic [mhd_pkg::SQ_W-1:0] out_sq_reg, out_sq_next;
    logic [mhd_pkg::Q8_W-1:0] out_q8_reg, out_q8_next;
    logic                     out_empty_reg, out_empty_next;
    logic                     out_ovf_reg, out_ovf_next;

    logic [CMPW-1:0] width_wide;
    logic [EW-1:0]   eff_width;
    logic            accept;
    logic            is_compute;
    logic            pixel_active;
    logic            take_first, take_second;
    logic            sets_empty;
    logic            clear;
    logic            scan_start;
    logic            root_start;

    logic [CW-1:0] count_first, count_second;
    logic          we_first, we_second;
    logic [AW-1:0] waddr_first, waddr_second;
    logic [PW-1:0] wdata_first, wdata_second;
    logic          drop_first, drop_second;
    logic [AW-1:0] raddr_first, raddr_second;
    logic [PW-1:0] rdata_first, rdata_second;
    logic          scan_done;
    logic [DW-1:0] best;
    logic          root_done;
    logic [QW-1:0] root;
    logic [RADW-1:0] radicand;

    // Clamp the programmed width into the range that the counters can cover.
    always_comb
    begin
        width_wide = CMPW'(image_width_reg);
        if (width_wide == '0)
        begin
            eff_width = EW'(1);
        end
        else if (width_wide > CMPW'(MAX_DIM))
        begin
            eff_width = EW'(MAX_DIM);
        end
        else
        begin
            eff_width = width_wide[EW-1:0];
        end
    end

    // Pixel words are only taken while no compute pass is in flight.
    assign pixels.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;

    assign accept       = pixels.valid && pixels.ready;
    assign is_compute   = pixels.cmd == mhd_pkg::CMD_COMPUTE;
    assign pixel_active = pixels.pixel != '0;
    assign take_first   = accept && (pixels.cmd == mhd_pkg::CMD_FIRST);
    assign take_second  = accept && (pixels.cmd == mhd_pkg::CMD_SECOND);
    assign sets_empty   = (count_first == '0) || (count_second == '0);

    // Both sets and the overflow flag are cleared as the result moves to the pending slot.
    assign clear      = (accept && is_compute && sets_empty)
                        || ((state_reg == ST_ROOT) && root_done);
    assign scan_start = accept && is_compute && !sets_empty;
    assign root_start = (state_reg == ST_SCAN) && scan_done;
    assign radicand   = RADW'({best, {mhd_pkg::FRAC_SQ_BITS{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= mhd_pkg::WIDTH_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            image_width_reg <= cfg.data;
        end
    end

    always_comb
    begin
        overflow_next = overflow_reg;
        if (clear)
        begin
            overflow_next = 1'b0;
        end
        else if (drop_first || drop_second)
        begin
            overflow_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overflow_reg <= 1'b0;
        end
        else
        begin
            overflow_reg <= overflow_next;
        end
    end

    mhd_loader #(
        .MAX_DIM    (MAX_DIM),
        .MAX_POINTS (MAX_POINTS)
    ) u_load_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take_first),
        .active    (pixel_active),
        .clear     (clear),
        .eff_width (eff_width),
        .count     (count_first),
        .we        (we_first),
        .waddr     (waddr_first),
        .wdata     (wdata_first),
        .drop      (drop_first)
    );

    mhd_loader #(
        .MAX_DIM    (MAX_DIM),
        .MAX_POINTS (MAX_POINTS)
    ) u_load_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take_second),
        .active    (pixel_active),
        .clear     (clear),
        .eff_width (eff_width),
        .count     (count_second),
        .we        (we_second),
        .waddr     (waddr_second),
        .wdata     (wdata_second),
        .drop      (drop_second)
    );

    mhd_point_mem #(
        .DEPTH (MAX_POINTS),
        .WIDTH (PW)
    ) u_mem_first (
        .clk   (clk),
        .we    (we_first),
        .waddr (waddr_first),
        .wdata (wdata_first),
        .raddr (raddr_first),
        .rdata (rdata_first)
    );

    mhd_point_mem #(
        .DEPTH (MAX_POINTS),
        .WIDTH (PW)
    ) u_mem_second (
        .clk   (clk),
        .we    (we_second),
        .waddr (waddr_second),
        .wdata (wdata_second),
        .raddr (raddr_second),
        .rdata (rdata_second)
    );

    mhd_scan #(
        .MAX_DIM    (MAX_DIM),
        .MAX_POINTS (MAX_POINTS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (scan_start),
        .count_first  (count_first),
        .count_second (count_second),
        .raddr_first  (raddr_first),
        .raddr_second (raddr_second),
        .rdata_first  (rdata_first),
        .rdata_second (rdata_second),
        .done         (scan_done),
        .best         (best)
    );

    mhd_isqrt #(
        .RADW (RADW)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    // Sequencer and output register. The output register is freed by the consumer
    // independently, so a new pass may run while an older result still waits.
    always_comb
    begin
        state_next      = state_reg;
        pend_sq_next    = pend_sq_reg;
        pend_q8_next    = pend_q8_reg;
        pend_empty_next = pend_empty_reg;
        pend_ovf_next   = pend_ovf_reg;
        out_valid_next  = out_valid_reg;
        out_sq_next     = out_sq_reg;
        out_q8_next     = out_q8_reg;
        out_empty_next  = out_empty_reg;
        out_ovf_next    = out_ovf_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_compute)
                begin
                    pend_ovf_next = overflow_reg;
                    if (sets_empty)
                    begin
                        pend_sq_next    = '0;
                        pend_q8_next    = '0;
                        pend_empty_next = 1'b1;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        pend_empty_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    // Saturate the square here while the root is worked out.
                    if (SQE'(best) > SQE'(mhd_pkg::SQ_MAX))
                    begin
                        pend_sq_next = mhd_pkg::SQ_MAX;
                    end
                    else
                    begin
                        pend_sq_next = mhd_pkg::SQ_W'(SQE'(best));
                    end
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    if (QE'(root) > QE'(mhd_pkg::Q8_MAX))
                    begin
                        pend_q8_next = mhd_pkg::Q8_MAX;
                    end
                    else
                    begin
                        pend_q8_next = mhd_pkg::Q8_W'(QE'(root));
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_sq_next    = pend_sq_reg;
                    out_q8_next    = pend_q8_reg;
                    out_empty_next = pend_empty_reg;
                    out_ovf_next   = pend_ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            pend_sq_reg    <= '0;
            pend_q8_reg    <= '0;
            pend_empty_reg <= 1'b0;
            pend_ovf_reg   <= 1'b0;
            out_sq_reg     <= '0;
            out_q8_reg     <= '0;
            out_empty_reg  <= 1'b0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            pend_sq_reg    <= pend_sq_next;
            pend_q8_reg    <= pend_q8_next;
            pend_empty_reg <= pend_empty_next;
            pend_ovf_reg   <= pend_ovf_next;
            out_sq_reg     <= out_sq_next;
            out_q8_reg     <= out_q8_next;
            out_empty_reg  <= out_empty_next;
            out_ovf_reg    <= out_ovf_next;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.hausdorff_squared = out_sq_reg;
    assign results.hausdorff_q8      = out_q8_reg;
    assign results.either_empty      = out_empty_reg;
    assign results.overflow          = out_ovf_reg;

endmodule

@@ src/mhd_checker.sv @@
module mhd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [mhd_pkg::CMD_W-1:0]    in_cmd,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [mhd_pkg::SQ_W-1:0]     out_squared,
    input logic [mhd_pkg::Q8_W-1:0]     out_q8,
    input logic                         out_empty
);

    // A stalled result word must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_squared) && $stable(out_q8))
    else $error("result word changed while stalled");

    // A compute word always occupies the block for at least the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_cmd == mhd_pkg::CMD_COMPUTE) |=> !in_ready)
    else $error("pixel port ready straight after a compute word");

    // An empty set forces both distances to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_empty |-> (out_squared == '0) && (out_q8 == '0))
    else $error("empty set gave a nonzero distance");

    // The root is zero exactly when the square is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_squared == '0) == (out_q8 == '0)))
    else $error("square and root disagree on zero");

    // A new result only appears after the block has been busy computing.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a compute pass");

endmodule

bind mask_hausdorff_distance mhd_checker u_mhd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (pixels.valid),
    .in_ready    (pixels.ready),
    .in_cmd      (pixels.cmd),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_squared (results.hausdorff_squared),
    .out_q8      (results.hausdorff_q8),
    .out_empty   (results.either_empty)
);
